// ----- rtl/melody_tone_sequencer_core_macros.svh -----
// Assertion macros used by the checker file of the tone sequencer.
`ifndef MELODY_TONE_SEQUENCER_CORE_MACROS_SVH
`define MELODY_TONE_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define MTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone sequencer check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define MTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone sequencer check failed");

// The condition must hold in the cycle right after a reset cycle.
`define MTS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("tone sequencer reset check failed");

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  localparam int NOTE_ROM_DEPTH = 32;
  localparam int ROM_AW = $clog2(NOTE_ROM_DEPTH);
  localparam int ADDR_W = ROM_AW + 2;

  localparam int FREQ_W = 16;
  localparam int DUR_W = 16;
  localparam int ELAPSED_W = 17;
  localparam int ID_W = 3;
  localparam int IDX_W = 3;
  localparam int PRESCALE_W = 20;
  localparam int DIV_CNT_W = $clog2(PRESCALE_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ID_W-1:0] ID_ALERT = 3'd1;
  localparam logic [ID_W-1:0] ID_ALERT_FAST = 3'd2;
  localparam logic [ID_W-1:0] ID_WARNING = 3'd3;
  localparam logic [ID_W-1:0] ID_OK = 3'd4;
  localparam logic [ID_W-1:0] ID_LAST_ROM = 3'd4;
  localparam logic [ID_W-1:0] ID_CUSTOM = 3'd5;

  localparam logic [PRESCALE_W-1:0] PRESCALE_BASE = 20'd720000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_BEEP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESTART,
    ST_DIVIDE,
    ST_WRITE
  } seq_state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic              rep;
    logic              verr;
    logic [FREQ_W-1:0] bfreq;
    logic [DUR_W-1:0]  bdur;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Note lists of the five built-in melodies, each closed by a terminator.
  function automatic note_t rom_note(input logic [ROM_AW-1:0] addr);
    note_t n;
    case (int'(addr))
      0:  n = {16'd523, 16'd120};
      1:  n = {16'd622, 16'd120};
      2:  n = {16'd698, 16'd120};
      3:  n = {16'd740, 16'd120};
      4:  n = {16'd784, 16'd120};
      6:  n = {16'd0, 16'd800};
      7:  n = {16'd600, 16'd200};
      8:  n = {16'd0, 16'd800};
      9:  n = {16'd600, 16'd200};
      11: n = {16'd2000, 16'd100};
      12: n = {16'd200, 16'd100};
      13: n = {16'd2000, 16'd100};
      14: n = {16'd200, 16'd100};
      16: n = {16'd800, 16'd200};
      17: n = {16'd400, 16'd200};
      18: n = {16'd200, 16'd0};
      19: n = {16'd200, 16'd400};
      21: n = {16'd698, 16'd150};
      22: n = {16'd659, 16'd80};
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] melody_start(input logic [ID_W-1:0] code);
    logic [ADDR_W-1:0] s;
    case (code)
      ID_ALERT:      s = ADDR_W'(6);
      ID_ALERT_FAST: s = ADDR_W'(11);
      ID_WARNING:    s = ADDR_W'(16);
      ID_OK:         s = ADDR_W'(21);
      default:       s = '0;
    endcase
    return s;
  endfunction

  // The custom melody is one note followed by silence; unknown ids read silence.
  function automatic note_t fetch_note(input logic [ID_W-1:0] code,
                                       input logic [IDX_W:0] idx,
                                       input logic [FREQ_W-1:0] cfreq,
                                       input logic [DUR_W-1:0] clen);
    note_t n;
    logic [ADDR_W-1:0] addr;
    n = '0;
    addr = melody_start(code) + ADDR_W'(idx);
    if (code == ID_CUSTOM) begin
      if (idx == '0) begin
        n = {cfreq, clen};
      end
    end else if (code <= ID_LAST_ROM && addr < ADDR_W'(NOTE_ROM_DEPTH)) begin
      n = rom_note(addr[ROM_AW-1:0]);
    end
    return n;
  endfunction

  function automatic logic is_term(input note_t n);
    return (n.freq == '0) && (n.dur == '0);
  endfunction

endpackage

// ----- rtl/mts_queue.sv -----
module mts_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mts_pkg::cmd_t         push_data,
  input  logic                  pop,
  output mts_pkg::cmd_t         head,
  output mts_pkg::queue_stat_t  qstat
);

  mts_pkg::cmd_t entries [mts_pkg::QUEUE_DEPTH];
  logic [mts_pkg::QPTR_W-1:0] wr_ptr;
  logic [mts_pkg::QPTR_W-1:0] rd_ptr;
  logic [mts_pkg::QCNT_W-1:0] count;

  function automatic logic [mts_pkg::QPTR_W-1:0] ptr_inc(
      input logic [mts_pkg::QPTR_W-1:0] p);
    return (p == mts_pkg::QPTR_W'(mts_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full = (count == mts_pkg::QCNT_W'(mts_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/mts_front.sv -----
module mts_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   func,
  input  logic [mts_pkg::ID_W-1:0]     melody_id,
  input  logic                         repeat_request,
  input  logic                         supply_fault,
  input  logic [mts_pkg::FREQ_W-1:0]   beep_freq,
  input  logic [mts_pkg::DUR_W-1:0]    beep_duration,
  input  mts_pkg::queue_stat_t         qstat,
  output logic                         push,
  output mts_pkg::cmd_t                push_data
);

  logic hold_valid;
  mts_pkg::cmd_t hold;
  mts_pkg::cmd_t decoded;
  logic accept;

  // A beep is a play of the custom melody without repeat.
  always_comb begin
    decoded.op = mts_pkg::op_t'(func);
    decoded.id = melody_id;
    decoded.rep = repeat_request;
    decoded.verr = supply_fault;
    decoded.bfreq = beep_freq;
    decoded.bdur = beep_duration;
    if (decoded.op == mts_pkg::OP_BEEP) begin
      decoded.id = mts_pkg::ID_CUSTOM;
      decoded.rep = 1'b0;
    end
  end

  assign push = hold_valid && !qstat.full;
  assign push_data = hold;
  assign req_stall = hold_valid && qstat.full;
  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

endmodule

// ----- rtl/mts_back.sv -----
module mts_back (
  input  logic                             clk,
  input  logic                             rst,
  input  mts_pkg::queue_stat_t             qstat,
  input  mts_pkg::cmd_t                    head,
  output logic                             pop,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [mts_pkg::FREQ_W-1:0]       tone_freq,
  output logic                             tone_on,
  output logic [mts_pkg::PRESCALE_W-1:0]   timer_prescale,
  output logic                             playing,
  output logic [mts_pkg::ID_W-1:0]         current_melody,
  output logic                             alert_active,
  output logic                             request_ignored
);

  mts_pkg::seq_state_t state, state_next;
  mts_pkg::cmd_t cmd, cmd_next;
  logic [mts_pkg::ID_W-1:0] melody_code, melody_code_next;
  logic [mts_pkg::IDX_W-1:0] note_index, note_index_next;
  logic sequencing, sequencing_next;
  logic repeat_on, repeat_on_next;
  logic [mts_pkg::ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [mts_pkg::FREQ_W-1:0] sounding_freq, sounding_freq_next;
  logic [mts_pkg::FREQ_W-1:0] custom_freq, custom_freq_next;
  logic [mts_pkg::DUR_W-1:0] custom_length, custom_length_next;
  logic ignored, ignored_next;
  logic [mts_pkg::FREQ_W:0] rem, rem_next;
  logic [mts_pkg::PRESCALE_W-1:0] quot, quot_next;
  logic [mts_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic rsp_valid_next;
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mts_pkg::ST_IDLE;
      melody_code <= '0;
      note_index <= '0;
      sequencing <= 1'b0;
      repeat_on <= 1'b0;
      elapsed_ms <= '0;
      sounding_freq <= '0;
      custom_freq <= '0;
      custom_length <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      melody_code <= melody_code_next;
      note_index <= note_index_next;
      sequencing <= sequencing_next;
      repeat_on <= repeat_on_next;
      elapsed_ms <= elapsed_ms_next;
      sounding_freq <= sounding_freq_next;
      custom_freq <= custom_freq_next;
      custom_length <= custom_length_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    ignored <= ignored_next;
    rem <= rem_next;
    quot <= quot_next;
    div_cnt <= div_cnt_next;
    if (out_load) begin
      tone_freq <= sounding_freq;
      tone_on <= (sounding_freq != '0);
      timer_prescale <= (sounding_freq != '0) ? quot : '0;
      playing <= sequencing;
      current_melody <= melody_code;
      alert_active <= (melody_code == mts_pkg::ID_ALERT);
      request_ignored <= ignored;
    end
  end

  always_comb begin
    mts_pkg::note_t cur_note;
    mts_pkg::note_t ent_note;
    logic [mts_pkg::ELAPSED_W-1:0] el_inc;
    logic do_enter;
    logic [mts_pkg::IDX_W:0] ent_idx;
    logic [mts_pkg::FREQ_W:0] shifted;
    logic ge;
    logic rejected;

    state_next = state;
    cmd_next = cmd;
    melody_code_next = melody_code;
    note_index_next = note_index;
    sequencing_next = sequencing;
    repeat_on_next = repeat_on;
    elapsed_ms_next = elapsed_ms;
    sounding_freq_next = sounding_freq;
    custom_freq_next = custom_freq;
    custom_length_next = custom_length;
    ignored_next = ignored;
    rem_next = rem;
    quot_next = quot;
    div_cnt_next = div_cnt;
    rsp_valid_next = rsp_valid && rsp_stall;
    out_load = 1'b0;
    pop = 1'b0;

    cur_note = mts_pkg::fetch_note(melody_code, {1'b0, note_index},
                                   custom_freq, custom_length);
    el_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 1'b1;
    ent_note = '0;
    do_enter = 1'b0;
    ent_idx = {1'b0, note_index} + 1'b1;
    shifted = {rem[mts_pkg::FREQ_W-1:0], quot[mts_pkg::PRESCALE_W-1]};
    ge = (shifted >= {1'b0, sounding_freq});
    rejected = ((cmd.id == melody_code) && sequencing && (melody_code != mts_pkg::ID_CUSTOM))
               || (cmd.verr && (cmd.id != mts_pkg::ID_ALERT)
                   && (cmd.id != mts_pkg::ID_ALERT_FAST));

    case (state)
      mts_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          cmd_next = head;
          state_next = mts_pkg::ST_EXEC;
        end
      end

      mts_pkg::ST_EXEC: begin
        ignored_next = 1'b0;
        rem_next = '0;
        quot_next = mts_pkg::PRESCALE_BASE;
        div_cnt_next = '0;
        state_next = mts_pkg::ST_DIVIDE;
        case (cmd.op)
          mts_pkg::OP_TICK: begin
            if (sequencing) begin
              if (el_inc > mts_pkg::ELAPSED_W'(cur_note.dur)) begin
                do_enter = 1'b1;
              end else begin
                elapsed_ms_next = el_inc;
              end
            end
          end
          mts_pkg::OP_STOP: begin
            sounding_freq_next = '0;
            sequencing_next = 1'b0;
            repeat_on_next = 1'b0;
          end
          mts_pkg::OP_PLAY, mts_pkg::OP_BEEP: begin
            if (cmd.op == mts_pkg::OP_BEEP) begin
              custom_freq_next = cmd.bfreq;
              custom_length_next = cmd.bdur;
            end
            if (rejected) begin
              ignored_next = 1'b1;
            end else begin
              melody_code_next = cmd.id;
              if (cmd.id > mts_pkg::ID_CUSTOM) begin
                sequencing_next = 1'b0;
              end else begin
                repeat_on_next = cmd.rep;
                ent_idx = '0;
                do_enter = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase

        if (do_enter) begin
          ent_note = mts_pkg::fetch_note(melody_code_next, ent_idx,
                                         custom_freq_next, custom_length_next);
          sounding_freq_next = ent_note.freq;
          note_index_next = ent_idx[mts_pkg::IDX_W-1:0];
          elapsed_ms_next = '0;
          sequencing_next = 1'b1;
          if (mts_pkg::is_term(ent_note)) begin
            if (repeat_on_next && (ent_idx != '0)) begin
              state_next = mts_pkg::ST_RESTART;
            end else begin
              sequencing_next = 1'b0;
            end
          end
        end
      end

      // Terminator reached with repeat on: go back to the first note once.
      mts_pkg::ST_RESTART: begin
        ent_note = mts_pkg::fetch_note(melody_code, '0, custom_freq, custom_length);
        sounding_freq_next = ent_note.freq;
        note_index_next = '0;
        elapsed_ms_next = '0;
        if (mts_pkg::is_term(ent_note)) begin
          sequencing_next = 1'b0;
        end
        state_next = mts_pkg::ST_DIVIDE;
      end

      // Restoring division, one quotient bit per cycle.
      mts_pkg::ST_DIVIDE: begin
        rem_next = ge ? shifted - {1'b0, sounding_freq} : shifted;
        quot_next = {quot[mts_pkg::PRESCALE_W-2:0], ge};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == mts_pkg::DIV_CNT_W'(mts_pkg::PRESCALE_W - 1)) begin
          state_next = mts_pkg::ST_WRITE;
        end
      end

      mts_pkg::ST_WRITE: begin
        if (!rsp_valid || !rsp_stall) begin
          out_load = 1'b1;
          rsp_valid_next = 1'b1;
          state_next = mts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/melody_tone_sequencer_core.sv -----
// Buzzer melody sequencer. Each accepted item is a one-millisecond tick, a
// play request, a stop or a beep, and each item yields exactly one result
// item that reports the tone now sounding, its tone timer prescale
// (720000 divided by the frequency, 0 when silent) and the playback status.
// A front stage registers and classifies incoming items and hands them to a
// two-entry queue; the back end pops one item at a time, updates the
// sequencer state from the note ROM, then works out the prescale with a
// bit-serial restoring divider, one step per bit of the 20-bit quotient.
// The result is written to an output register once any earlier result
// there has been taken, so the back end already works on the next item
// while a result waits, and the front keeps taking items until the queue
// and its own register are full. A melody in repeat mode that wraps from
// its terminator to its first note adds a restart step. The control
// state comes up zero after reset with no clearing pass, so items are
// accepted right away. Play rules: a repeat play of the melody already
// sequencing is ignored unless it is the custom melody, a supply fault
// admits only the two alert melodies, an unknown id stops sequencing but
// keeps the tone, and a beep loads the custom note and, unless a supply
// fault turns it down, restarts it without repeat.
module melody_tone_sequencer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [1:0]                       func,
  input  logic [mts_pkg::ID_W-1:0]         melody_id,
  input  logic                             repeat_request,
  input  logic                             supply_fault,
  input  logic [mts_pkg::FREQ_W-1:0]       beep_freq,
  input  logic [mts_pkg::DUR_W-1:0]        beep_duration,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [mts_pkg::FREQ_W-1:0]       tone_freq,
  output logic                             tone_on,
  output logic [mts_pkg::PRESCALE_W-1:0]   timer_prescale,
  output logic                             playing,
  output logic [mts_pkg::ID_W-1:0]         current_melody,
  output logic                             alert_active,
  output logic                             request_ignored
);

  // Queue fill state seen by both the front (full) and the back (empty).
  mts_pkg::queue_stat_t qstat;
  logic push;
  logic pop;
  mts_pkg::cmd_t push_data;
  mts_pkg::cmd_t head;

  // Front: input register and request decode; a beep becomes a play of the
  // custom melody with repeat off.
  mts_front u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .func           (func),
    .melody_id      (melody_id),
    .repeat_request (repeat_request),
    .supply_fault   (supply_fault),
    .beep_freq      (beep_freq),
    .beep_duration  (beep_duration),
    .qstat          (qstat),
    .push           (push),
    .push_data      (push_data)
  );

  // Short queue that lets the front keep accepting while the back divides.
  mts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Back: sequencer state machine, note ROM, prescale divider, output register.
  mts_back u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .head            (head),
    .pop             (pop),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .tone_freq       (tone_freq),
    .tone_on         (tone_on),
    .timer_prescale  (timer_prescale),
    .playing         (playing),
    .current_melody  (current_melody),
    .alert_active    (alert_active),
    .request_ignored (request_ignored)
  );

endmodule

// ----- rtl/mts_checker.sv -----
`include "melody_tone_sequencer_core_macros.svh"

module mts_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_stall,
  input logic [mts_pkg::FREQ_W-1:0]       tone_freq,
  input logic                             tone_on,
  input logic [mts_pkg::PRESCALE_W-1:0]   timer_prescale,
  input logic [mts_pkg::ID_W-1:0]         current_melody,
  input logic                             alert_active
);

  // No result is offered right after reset.
  `MTS_ASSERT_AFTER_RESET(a_no_result_after_reset, !rsp_valid)

  // A stalled result stays offered and unchanged.
  `MTS_ASSERT_NEXT(a_result_held, rsp_valid && rsp_stall, rsp_valid && $stable(tone_freq) && $stable(timer_prescale))

  // The divider result agrees with the sounding frequency.
  `MTS_ASSERT_SAME(a_prescale_matches_tone, rsp_valid, (tone_on == (tone_freq != '0)) && ((timer_prescale != '0) == tone_on))

  // The alert flag follows the reported melody.
  `MTS_ASSERT_SAME(a_alert_flag, rsp_valid, alert_active == (current_melody == mts_pkg::ID_ALERT))

endmodule

bind melody_tone_sequencer_core mts_checker u_mts_checker (.*);

// ----- dv/tb.sv -----
module tb;
  import mts_pkg::*;

  // Clock period, number of items in the whole run and the safety limit on
  // the run. The limit assumes every item waits out the longest sender gap,
  // the back end and a heavily stalled receiver, then doubles that several
  // times over.
  localparam int CLK_PERIOD = 10;
  localparam int TOTAL_ITEMS = 450;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_RESULTS = 60;
  localparam int PAUSE_AFTER_ITEMS = 200;
  localparam int DRAIN_CYCLES = 60;

  // Melody ids used by the directed table.
  localparam logic [ID_W-1:0] MEL_BOOT = 3'd0;
  localparam logic [ID_W-1:0] MEL_WARNING = 3'd3;
  localparam logic [ID_W-1:0] MEL_OK = 3'd4;
  localparam logic [ID_W-1:0] MEL_UNKNOWN_LO = 3'd6;
  localparam logic [ID_W-1:0] MEL_UNKNOWN_HI = 3'd7;

  localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

  // Note lists of the five built-in melodies, packed back to back. Each list
  // ends in a note of zero frequency and zero length.
  localparam int ROM_WORDS = 24;
  localparam logic [FREQ_W-1:0] ROM_FREQ [ROM_WORDS] = '{
    523, 622, 698, 740, 784, 0,
    0, 600, 0, 600, 0,
    2000, 200, 2000, 200, 0,
    800, 400, 200, 200, 0,
    698, 659, 0
  };
  localparam logic [DUR_W-1:0] ROM_DUR [ROM_WORDS] = '{
    120, 120, 120, 120, 120, 0,
    800, 200, 800, 200, 0,
    100, 100, 100, 100, 0,
    200, 200, 0, 400, 0,
    150, 80, 0
  };
  localparam int MELODY_BASE [5] = '{0, 6, 11, 16, 21};

  // One result item, field by field.
  typedef struct packed {
    logic [FREQ_W-1:0]     tone_freq;
    logic                  tone_on;
    logic [PRESCALE_W-1:0] prescale;
    logic                  playing;
    logic [ID_W-1:0]       melody;
    logic                  alert;
    logic                  ignored;
  } tone_status_t;

  // One row of the directed table. Where known is set, the status typed into
  // the row is what the block must return; otherwise the predictor decides.
  typedef struct {
    cmd_t         cmd;
    bit           known;
    tone_status_t status;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  logic [1:0]            func;
  logic [ID_W-1:0]       melody_id;
  logic                  repeat_request;
  logic                  supply_fault;
  logic [FREQ_W-1:0]     beep_freq;
  logic [DUR_W-1:0]      beep_duration;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic [FREQ_W-1:0]     tone_freq;
  logic                  tone_on;
  logic [PRESCALE_W-1:0] timer_prescale;
  logic                  playing;
  logic [ID_W-1:0]       current_melody;
  logic                  alert_active;
  logic                  request_ignored;

  melody_tone_sequencer_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .func            (func),
    .melody_id       (melody_id),
    .repeat_request  (repeat_request),
    .supply_fault    (supply_fault),
    .beep_freq       (beep_freq),
    .beep_duration   (beep_duration),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .tone_freq       (tone_freq),
    .tone_on         (tone_on),
    .timer_prescale  (timer_prescale),
    .playing         (playing),
    .current_melody  (current_melody),
    .alert_active    (alert_active),
    .request_ignored (request_ignored)
  );

  // Sequencer state as the predictor sees it. It is updated in the order in
  // which the block accepts items, so it always reflects every item sent.
  logic [ID_W-1:0]      seq_melody = '0;
  logic [IDX_W-1:0]     seq_index = '0;
  logic                 seq_active = 1'b0;
  logic                 seq_repeat = 1'b0;
  logic [ELAPSED_W-1:0] seq_elapsed = '0;
  logic [FREQ_W-1:0]    seq_freq = '0;
  logic [FREQ_W-1:0]    cust_freq = '0;
  logic [DUR_W-1:0]     cust_len = '0;

  tone_status_t pending_status[$];
  step_row_t    directed_plan[$];
  int           fail_count = 0;
  int           results_seen = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  int           cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Note idx of the melody now selected. The custom melody is the beep note
  // followed by a terminator, and unknown ids read as a terminator.
  function automatic note_t note_at(input logic [ID_W-1:0] code, input int idx);
    note_t n;
    int    addr;
    n = '0;
    if (code == ID_CUSTOM) begin
      if (idx == 0) begin
        n.freq = cust_freq;
        n.dur = cust_len;
      end
    end else if (code <= MEL_OK) begin
      addr = MELODY_BASE[code] + idx;
      if (addr < ROM_WORDS) begin
        n.freq = ROM_FREQ[addr];
        n.dur = ROM_DUR[addr];
      end
    end
    return n;
  endfunction

  // Moves to note idx. A terminator wraps to the first note once when repeat
  // is on and the terminator is not the first note; otherwise playback stops
  // in silence. An empty custom note therefore ends playback at once.
  function automatic void enter_note(input int first);
    note_t n;
    int    idx;
    bit    wrapped;
    bit    done;
    idx = first;
    wrapped = 1'b0;
    done = 1'b0;
    while (!done) begin
      n = note_at(seq_melody, idx);
      seq_freq = n.freq;
      seq_index = idx[IDX_W-1:0];
      seq_elapsed = '0;
      seq_active = 1'b1;
      if (n.freq != '0 || n.dur != '0) begin
        done = 1'b1;
      end else if (seq_repeat && !wrapped && idx != 0) begin
        wrapped = 1'b1;
        idx = 0;
      end else begin
        seq_active = 1'b0;
        done = 1'b1;
      end
    end
  endfunction

  // Applies the play rules; returns 1 when the request is taken.
  function automatic bit accept_play(input logic [ID_W-1:0] id, input logic rep,
                                     input logic verr);
    if (id == seq_melody && seq_active && seq_melody != ID_CUSTOM) begin
      return 1'b0;
    end
    if (verr && id != ID_ALERT && id != ID_ALERT_FAST) begin
      return 1'b0;
    end
    seq_melody = id;
    if (id > ID_CUSTOM) begin
      // Unknown melody: sequencing stops, tone and repeat stay as they are.
      seq_active = 1'b0;
      return 1'b1;
    end
    seq_repeat = rep;
    enter_note(0);
    return 1'b1;
  endfunction

  // Advances the predicted sequencer by one item and returns its status.
  function automatic tone_status_t sequencer_step(input cmd_t c);
    tone_status_t s;
    note_t        n;
    logic         ign;
    ign = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (seq_active) begin
          n = note_at(seq_melody, int'(seq_index));
          if (seq_elapsed != ELAPSED_TOP) begin
            seq_elapsed = seq_elapsed + 1'b1;
          end
          if (seq_elapsed > ELAPSED_W'(n.dur)) begin
            enter_note(int'(seq_index) + 1);
          end
        end
      end
      OP_PLAY: begin
        ign = !accept_play(c.id, c.rep, c.verr);
      end
      OP_STOP: begin
        seq_freq = '0;
        seq_active = 1'b0;
        seq_repeat = 1'b0;
      end
      OP_BEEP: begin
        // The custom note is loaded even when the request is turned down.
        cust_freq = c.bfreq;
        cust_len = c.bdur;
        ign = !accept_play(ID_CUSTOM, 1'b0, c.verr);
      end
      default: begin
      end
    endcase
    s.tone_freq = seq_freq;
    s.tone_on = (seq_freq != '0);
    s.prescale = (seq_freq != '0) ? PRESCALE_BASE / PRESCALE_W'(seq_freq) : '0;
    s.playing = seq_active;
    s.melody = seq_melody;
    s.alert = (seq_melody == ID_ALERT);
    s.ignored = ign;
    return s;
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input logic [ID_W-1:0] id,
                                    input logic rep, input logic verr,
                                    input logic [FREQ_W-1:0] bf,
                                    input logic [DUR_W-1:0] bd);
    cmd_t c;
    c.op = op;
    c.id = id;
    c.rep = rep;
    c.verr = verr;
    c.bfreq = bf;
    c.bdur = bd;
    return c;
  endfunction

  // Typed status for the directed rows; tone_on and alert follow directly.
  function automatic tone_status_t status_of(input logic [FREQ_W-1:0] freq,
                                             input logic [PRESCALE_W-1:0] ps,
                                             input logic play,
                                             input logic [ID_W-1:0] mel,
                                             input logic ign);
    tone_status_t s;
    s.tone_freq = freq;
    s.tone_on = (freq != '0);
    s.prescale = ps;
    s.playing = play;
    s.melody = mel;
    s.alert = (mel == ID_ALERT);
    s.ignored = ign;
    return s;
  endfunction

  function automatic void add_row(input op_t op, input logic [ID_W-1:0] id,
                                  input logic rep, input logic verr,
                                  input logic [FREQ_W-1:0] bf,
                                  input logic [DUR_W-1:0] bd,
                                  input bit known, input tone_status_t st);
    step_row_t r;
    r.cmd = make_cmd(op, id, rep, verr, bf, bd);
    r.known = known;
    r.status = st;
    directed_plan.push_back(r);
  endfunction

  // A tick with every other field random, since a tick ignores them.
  function automatic cmd_t random_tick();
    return make_cmd(OP_TICK, ID_W'($urandom), 1'($urandom), 1'($urandom),
                    FREQ_W'($urandom), DUR_W'($urandom));
  endfunction

  // Beep frequencies lean on silence, low tones and the top of the range.
  function automatic logic [FREQ_W-1:0] random_freq();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return FREQ_W'($urandom_range(1, 50));
      2: return FREQ_W'($urandom);
      default: return FREQ_W'(16'hFFFF - $urandom_range(0, 3));
    endcase
  endfunction

  // Beeps are mostly short so that ticks carry them to their end.
  function automatic logic [DUR_W-1:0] random_dur();
    if ($urandom_range(0, 7) == 0) begin
      return DUR_W'($urandom);
    end
    return DUR_W'($urandom_range(0, 10));
  endfunction

  function automatic logic random_fault();
    return ($urandom_range(0, 9) == 0);
  endfunction

  // Offers one item and waits for the block to take it. The sender works in
  // bursts: once a burst is used up, valid drops for a random gap. Inputs
  // change on the falling edge only; acceptance is judged on the rising edge.
  task automatic send_item(input cmd_t c, input bit known, input tone_status_t typed);
    tone_status_t s;
    if (burst_left == 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    req_valid = 1'b1;
    func = c.op;
    melody_id = c.id;
    repeat_request = c.rep;
    supply_fault = c.verr;
    beep_freq = c.bfreq;
    beep_duration = c.bdur;
    do @(posedge clk); while (req_stall);
    items_sent++;
    s = sequencer_step(c);
    pending_status.push_back(known ? typed : s);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    req_valid = 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: every accepted result item is matched with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_check
    tone_status_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result item with none expected, tone_freq %0d", $time, tone_freq);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("tone_freq", int'(want.tone_freq), int'(tone_freq));
        check_field("tone_on", int'(want.tone_on), int'(tone_on));
        check_field("timer_prescale", int'(want.prescale), int'(timer_prescale));
        check_field("playing", int'(want.playing), int'(playing));
        check_field("current_melody", int'(want.melody), int'(current_melody));
        check_field("alert_active", int'(want.alert), int'(alert_active));
        check_field("request_ignored", int'(want.ignored), int'(request_ignored));
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               pending_status.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. It switches between stretches of no stalling, even stalling
  // and heavy stalling. Once enough results have come it holds off for a
  // long stretch while the sender keeps offering, so the queue fills and
  // the block has to stall its input.
  initial begin : receiver
    int  mode;
    int  mode_left;
    bit  held;
    rsp_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER_RESULTS) begin
        held = 1'b1;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: rsp_stall = 1'b0;
        1: rsp_stall = ($urandom_range(0, 1) == 1);
        default: rsp_stall = ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  initial begin : stimulus
    int  pick;
    int  ticks;
    bit  paused;
    rst = 1'b1;
    req_valid = 1'b0;
    func = OP_TICK;
    melody_id = '0;
    repeat_request = 1'b0;
    supply_fault = 1'b0;
    beep_freq = '0;
    beep_duration = '0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Prescales are 720000 divided by the tone, truncated.
    // Tick while idle right after reset: all quiet.
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 1, status_of(0, 0, 0, MEL_BOOT, 0));
    // Unknown id from idle: taken as the current melody, nothing sounds.
    add_row(OP_PLAY, MEL_UNKNOWN_LO, 0, 0, 0, 0, 1,
            status_of(0, 0, 0, MEL_UNKNOWN_LO, 0));
    // Beep at the top of both fields.
    add_row(OP_BEEP, MEL_BOOT, 0, 0, 16'hFFFF, 16'hFFFF, 1,
            status_of(16'hFFFF, 10, 1, ID_CUSTOM, 0));
    // Custom melody replaying itself is allowed; lowest tone, longest prescale.
    add_row(OP_BEEP, MEL_BOOT, 0, 0, 1, 0, 1, status_of(1, 720000, 1, ID_CUSTOM, 0));
    // A zero-length note ends after one tick, without repeat.
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 1, status_of(0, 0, 0, ID_CUSTOM, 0));
    // Voltage fault admits the alert melody; it opens with a silent note.
    add_row(OP_PLAY, ID_ALERT, 0, 1, 0, 0, 1, status_of(0, 0, 1, ID_ALERT, 0));
    // Same melody while it plays is turned down.
    add_row(OP_PLAY, ID_ALERT, 1, 0, 0, 0, 1, status_of(0, 0, 1, ID_ALERT, 1));
    // Voltage fault turns down a non-alert melody.
    add_row(OP_PLAY, MEL_WARNING, 0, 1, 0, 0, 1, status_of(0, 0, 1, ID_ALERT, 1));
    add_row(OP_PLAY, ID_ALERT_FAST, 1, 1, 0, 0, 1,
            status_of(2000, 360, 1, ID_ALERT_FAST, 0));
    // A beep under a fault is turned down but still loads the custom note.
    add_row(OP_BEEP, MEL_BOOT, 0, 1, 500, 3, 1,
            status_of(2000, 360, 1, ID_ALERT_FAST, 1));
    add_row(OP_STOP, MEL_BOOT, 0, 0, 0, 0, 1, status_of(0, 0, 0, ID_ALERT_FAST, 0));
    // Custom melody with repeat: the note left by the rejected beep plays
    // and wraps around at its terminator on the fourth tick.
    add_row(OP_PLAY, ID_CUSTOM, 1, 0, 0, 0, 1, status_of(500, 1440, 1, ID_CUSTOM, 0));
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 0, '0);
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 0, '0);
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 0, '0);
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 0, '0);
    // Empty custom note ends at once, and still does so with repeat on.
    add_row(OP_BEEP, MEL_BOOT, 0, 0, 0, 0, 1, status_of(0, 0, 0, ID_CUSTOM, 0));
    add_row(OP_PLAY, ID_CUSTOM, 1, 0, 0, 0, 1, status_of(0, 0, 0, ID_CUSTOM, 0));
    add_row(OP_PLAY, MEL_UNKNOWN_HI, 0, 0, 0, 0, 1,
            status_of(0, 0, 0, MEL_UNKNOWN_HI, 0));
    add_row(OP_PLAY, MEL_OK, 0, 0, 0, 0, 1, status_of(698, 1031, 1, MEL_OK, 0));
    add_row(OP_PLAY, MEL_BOOT, 0, 0, 0, 0, 1, status_of(523, 1376, 1, MEL_BOOT, 0));
    add_row(OP_PLAY, MEL_WARNING, 1, 0, 0, 0, 1, status_of(800, 900, 1, MEL_WARNING, 0));
    add_row(OP_TICK, MEL_BOOT, 0, 0, 0, 0, 0, '0);
    // Unknown id while a melody plays: sequencing stops, the tone stays.
    add_row(OP_PLAY, MEL_UNKNOWN_LO, 1, 0, 0, 0, 1,
            status_of(800, 900, 0, MEL_UNKNOWN_LO, 0));
    add_row(OP_STOP, MEL_BOOT, 0, 0, 0, 0, 1, status_of(0, 0, 0, MEL_UNKNOWN_LO, 0));

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].cmd, directed_plan[i].known, directed_plan[i].status);
    end
    drain_results();

    // Random part: mostly well-formed sequences, a request followed by the
    // ticks that carry its notes forward, plus stops, repeated requests for
    // the melody in progress and fully random items as noise.
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      ticks = 0;
      if (pick < 40) begin
        send_item(make_cmd(OP_BEEP, ID_W'($urandom), 1'($urandom), random_fault(),
                           random_freq(), random_dur()), 0, '0);
        ticks = $urandom_range(0, 15);
      end else if (pick < 70) begin
        send_item(make_cmd(OP_PLAY, ID_W'($urandom), 1'($urandom), random_fault(),
                           FREQ_W'($urandom), DUR_W'($urandom)), 0, '0);
        // Now and then a long run reaches the end of a built-in melody.
        ticks = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 420)
                                             : $urandom_range(0, 30);
      end else if (pick < 80) begin
        send_item(make_cmd(OP_STOP, ID_W'($urandom), 1'($urandom), 1'($urandom),
                           FREQ_W'($urandom), DUR_W'($urandom)), 0, '0);
        ticks = $urandom_range(0, 3);
      end else if (pick < 90) begin
        send_item(make_cmd(OP_PLAY, seq_melody, 1'($urandom), random_fault(),
                           FREQ_W'($urandom), DUR_W'($urandom)), 0, '0);
        ticks = $urandom_range(0, 5);
      end else begin
        send_item(make_cmd(op_t'(2'($urandom)), ID_W'($urandom), 1'($urandom),
                           1'($urandom), FREQ_W'($urandom), DUR_W'($urandom)), 0, '0);
      end
      // The tick run never carries the run past its item count.
      if (ticks > TOTAL_ITEMS - items_sent) begin
        ticks = (items_sent < TOTAL_ITEMS) ? TOTAL_ITEMS - items_sent : 0;
      end
      repeat (ticks) send_item(random_tick(), 0, '0);
      // Once in the middle of the run the sender waits for the block to empty.
      if (!paused && items_sent >= PAUSE_AFTER_ITEMS) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_queue.sv
rtl/mts_front.sv
rtl/mts_back.sv
rtl/melody_tone_sequencer_core.sv
rtl/mts_checker.sv
dv/tb.sv
